>>> hdl/pfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfm_pkg;

  localparam int unsigned CNT_W       = 16;
  localparam int unsigned FLOW_W      = 23;
  localparam int unsigned LOW_W       = 4;
  localparam int unsigned ALARM_W     = 2;
  localparam int unsigned SCALE_W     = 7;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [CNT_W-1:0]   CNT_MAX    = 16'hFFFF;
  localparam logic [LOW_W-1:0]   LOW_MAX    = 4'd15;
  localparam logic [SCALE_W-1:0] FLOW_SCALE = 7'd95;

  localparam logic [CNT_W-1:0]  WINDOW_LIMIT_RST = 16'd1000;
  localparam logic [FLOW_W-1:0] LOW_FLOW_RST     = 23'd0;
  localparam logic [LOW_W-1:0]  ALARM_LIMIT_RST  = 4'd2;

  typedef enum logic [1:0] {
    REG_WINDOW_LIMIT = 2'd0,
    REG_LOW_FLOW_A   = 2'd1,
    REG_LOW_FLOW_B   = 2'd2,
    REG_ALARM_LIMIT  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_PULSE = 1'b1
  } op_e;

  typedef struct packed {
    logic [CNT_W-1:0]  window_limit;
    logic [FLOW_W-1:0] low_flow_limit_a;
    logic [FLOW_W-1:0] low_flow_limit_b;
    logic [LOW_W-1:0]  alarm_window_limit;
  } cfg_t;

  typedef struct packed {
    logic [LOW_W-1:0] low_windows;
    logic [CNT_W-1:0] pulse_count;
  } chan_entry_t;

endpackage

`default_nettype wire

>>> hdl/pfm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pfm_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pfm_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [pfm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [pfm_pkg::APB_DATA_W-1:0]   prdata,
  output pfm_pkg::cfg_t                         cfg_o
);

  pfm_pkg::cfg_t     cfg_q, cfg_d;
  pfm_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign reg_idx = pfm_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        pfm_pkg::REG_WINDOW_LIMIT: begin
          cfg_d.window_limit = pwdata[pfm_pkg::CNT_W-1:0];
        end
        pfm_pkg::REG_LOW_FLOW_A: begin
          cfg_d.low_flow_limit_a = pwdata[pfm_pkg::FLOW_W-1:0];
        end
        pfm_pkg::REG_LOW_FLOW_B: begin
          cfg_d.low_flow_limit_b = pwdata[pfm_pkg::FLOW_W-1:0];
        end
        pfm_pkg::REG_ALARM_LIMIT: begin
          cfg_d.alarm_window_limit = pwdata[pfm_pkg::LOW_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_limit       <= pfm_pkg::WINDOW_LIMIT_RST;
      cfg_q.low_flow_limit_a   <= pfm_pkg::LOW_FLOW_RST;
      cfg_q.low_flow_limit_b   <= pfm_pkg::LOW_FLOW_RST;
      cfg_q.alarm_window_limit <= pfm_pkg::ALARM_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      pfm_pkg::REG_WINDOW_LIMIT: prdata = pfm_pkg::APB_DATA_W'(cfg_q.window_limit);
      pfm_pkg::REG_LOW_FLOW_A:   prdata = pfm_pkg::APB_DATA_W'(cfg_q.low_flow_limit_a);
      pfm_pkg::REG_LOW_FLOW_B:   prdata = pfm_pkg::APB_DATA_W'(cfg_q.low_flow_limit_b);
      pfm_pkg::REG_ALARM_LIMIT:  prdata = pfm_pkg::APB_DATA_W'(cfg_q.alarm_window_limit);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hdl/pulse_flow_meter_low_flow_alarm_top.sv
// Two-channel pulse flow meter with latched low-flow alarm.
// Input stream: one beat per event. tuser = op (0 tick, 1 sensor pulse);
// tdata carries the pulse channel and that channel's interlock key level.
// Output stream: exactly one beat per input beat, in order. tuser = flow_valid,
// set when the pulse closed a window; tdata carries channel, reading
// (pulse count * 95), latched alarm bits and the laser-off request.
// Each beat is registered in the work stage, then the output register; one beat
// per cycle while the output is not stalled, set by the per-channel read-modify-write
// of the state memory (registered read, write-back from the work stage, forwarded
// to a following read). Window tick counters sit in flops since a tick updates
// every channel. Reset clears all counters and alarms at once (per-entry valid
// bits, no clearing pass) and loads register defaults. Registers are to be written
// over APB while the stream is idle; the block does not enforce it. A low m_axis_tready
// holds the output register; s_axis_tready drops once the work stage is full.
`timescale 1ns / 1ps
`default_nettype none

module pulse_flow_meter_low_flow_alarm_top #(
  parameter int unsigned NUM_CHANNELS = 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pfm_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [pfm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [pfm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [0] channel, [1] interlock_enable, zero fill above
  input  wire logic [pfm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] op
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] flow_channel, [23:1] flow_value, [25:24] alarm_bits, [26] laser_off
  output logic      [pfm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] flow_valid
  output logic                                   m_axis_tuser
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [1:0]  NUM_CH_L = 2'(NUM_CHANNELS);

  pfm_pkg::cfg_t cfg;

  pfm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign pready = 1'b1;

  // handshake
  logic in_fire, out_ready, s1_fire;
  logic s1_valid_q, s1_valid_d;
  logic m_valid_q, m_valid_d;

  assign out_ready     = !m_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && out_ready;
  assign s_axis_tready = !s1_valid_q || out_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // input decode
  logic            in_ch, in_range;
  logic [CH_W-1:0] rd_addr;

  assign in_ch    = s_axis_tdata[0];
  assign in_range = ({1'b0, in_ch} < NUM_CH_L);
  assign rd_addr  = in_range ? CH_W'(in_ch) : '0;

  // work stage item
  pfm_pkg::op_e s1_op_q;
  logic         s1_ch_q, s1_key_q, s1_range_q;

  // state memory
  pfm_pkg::chan_entry_t mem [NUM_CHANNELS];
  pfm_pkg::chan_entry_t rd_data_q, fwd_data_q, wr_data, cur;
  logic [NUM_CHANNELS-1:0] ent_vld_q, ent_vld_d;
  logic                    rd_vld_q, fwd_hit_q, wr_en;
  logic [CH_W-1:0]         wr_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      ent_vld_q <= ent_vld_d;
      if (in_fire) begin
        rd_vld_q  <= ent_vld_q[rd_addr];
        fwd_hit_q <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_data_q <= wr_data;
      s1_op_q    <= pfm_pkg::op_e'(s_axis_tuser);
      s1_ch_q    <= in_ch;
      s1_key_q   <= s_axis_tdata[1];
      s1_range_q <= in_range;
    end
  end

  always_comb begin
    ent_vld_d = ent_vld_q;
    if (wr_en) begin
      ent_vld_d[wr_addr] = 1'b1;
    end
  end

  assign cur = fwd_hit_q ? fwd_data_q : (rd_vld_q ? rd_data_q : '0);

  // update
  logic [pfm_pkg::CNT_W-1:0] win_ticks_q [NUM_CHANNELS];
  logic [pfm_pkg::CNT_W-1:0] win_ticks_d [NUM_CHANNELS];
  logic [pfm_pkg::ALARM_W-1:0] alarm_q, alarm_d;
  logic                        laser_q, laser_d;

  logic [CH_W-1:0]            ch_idx;
  logic                       pulse, close, is_low, alarm_hit;
  logic [pfm_pkg::CNT_W-1:0]  cnt_inc;
  logic [pfm_pkg::LOW_W-1:0]  low_inc;
  logic [pfm_pkg::FLOW_W-1:0] flow, limit;

  always_comb begin
    ch_idx    = s1_range_q ? CH_W'(s1_ch_q) : '0;
    pulse     = (s1_op_q == pfm_pkg::OP_PULSE) && s1_range_q;
    cnt_inc   = (cur.pulse_count < pfm_pkg::CNT_MAX) ? cur.pulse_count + 1'b1
                                                     : cur.pulse_count;
    close     = pulse && (win_ticks_q[ch_idx] > cfg.window_limit);
    flow      = pfm_pkg::FLOW_W'(cnt_inc) * pfm_pkg::FLOW_W'(pfm_pkg::FLOW_SCALE);
    limit     = s1_ch_q ? cfg.low_flow_limit_b : cfg.low_flow_limit_a;
    is_low    = (flow <= limit);
    low_inc   = (cur.low_windows < pfm_pkg::LOW_MAX) ? cur.low_windows + 1'b1
                                                     : cur.low_windows;
    alarm_hit = close && is_low && (low_inc > cfg.alarm_window_limit) && s1_key_q;

    wr_en   = s1_fire && pulse;
    wr_addr = ch_idx;
    wr_data.pulse_count = close ? '0 : cnt_inc;
    wr_data.low_windows = close ? (is_low ? low_inc : '0) : cur.low_windows;

    alarm_d = alarm_q;
    laser_d = laser_q;
    if (s1_fire && alarm_hit) begin
      alarm_d = alarm_q | (pfm_pkg::ALARM_W'(1) << s1_ch_q);
      laser_d = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
      win_ticks_d[i] = win_ticks_q[i];
      if (s1_fire) begin
        if (s1_op_q == pfm_pkg::OP_TICK) begin
          if (win_ticks_q[i] < pfm_pkg::CNT_MAX) begin
            win_ticks_d[i] = win_ticks_q[i] + 1'b1;
          end
        end else if (close && (i == int'(ch_idx))) begin
          win_ticks_d[i] = '0;
        end
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    if (s1_fire) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      alarm_q    <= '0;
      laser_q    <= 1'b0;
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        win_ticks_q[i] <= '0;
      end
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
      alarm_q    <= alarm_d;
      laser_q    <= laser_d;
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        win_ticks_q[i] <= win_ticks_d[i];
      end
    end
  end

  // output register
  logic [pfm_pkg::OUT_TDATA_W-1:0] m_tdata_q;
  logic                            m_tuser_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      m_tuser_q <= close;
      m_tdata_q <= {5'b0, laser_d, alarm_d, (close ? flow : '0),
                    (s1_op_q == pfm_pkg::OP_PULSE) ? s1_ch_q : 1'b0};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

`default_nettype wire

>>> verif/tb_pulse_flow_meter_low_flow_alarm_top.sv
`timescale 1ns / 1ps

module tb_pulse_flow_meter_low_flow_alarm_top;

  localparam int unsigned FLOW_PER_PULSE = 95;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned HOLD_CYCLES    = 40;
  localparam int unsigned PHASE_BEATS    = 90;
  localparam int unsigned N_STEPS        = 16;

  typedef struct packed {
    logic                       valid;
    logic                       chan;
    logic [pfm_pkg::FLOW_W-1:0] value;
    logic [1:0]                 alarm;
    logic                       laser;
  } flow_rsp_t;

  typedef enum logic {
    STEP_BEAT = 1'b0,
    STEP_REG  = 1'b1
  } step_e;

  typedef struct packed {
    step_e             kind;
    pfm_pkg::reg_idx_e idx;
    logic [31:0]       val;
    pfm_pkg::op_e      op;
    logic              ch;
    logic              key;
    logic              typed;
    flow_rsp_t         want;
  } step_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [pfm_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [pfm_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [pfm_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  logic                            s_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [pfm_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                            s_tuser  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_tready = 1'b0;
  logic [pfm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  // predictor state and register copy
  logic [pfm_pkg::CNT_W-1:0]  mtr_pulses [2] = '{16'd0, 16'd0};
  logic [pfm_pkg::CNT_W-1:0]  mtr_ticks  [2] = '{16'd0, 16'd0};
  logic [pfm_pkg::LOW_W-1:0]  mtr_low    [2] = '{4'd0, 4'd0};
  logic [1:0]                 mtr_alarm      = 2'b00;
  logic                       mtr_laser      = 1'b0;
  logic [pfm_pkg::CNT_W-1:0]  cfg_window     = 16'd1000;
  logic [pfm_pkg::FLOW_W-1:0] cfg_low    [2] = '{23'd0, 23'd0};
  logic [pfm_pkg::LOW_W-1:0]  cfg_alarm_lim  = 4'd2;

  flow_rsp_t flow_q [$];

  bit idle_on      = 1'b1;
  bit hold_off_req = 1'b0;
  int mismatches   = 0;
  int beats_in     = 0;
  int beats_out    = 0;
  int readings     = 0;
  int reg_writes   = 0;
  int quiet_cycles = 0;

  step_t script [N_STEPS] = '{
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_TICK, 1'b1, 1'b1, 1'b1,
      '{1'b0, 1'b0, 23'd0, 2'b00, 1'b0}},
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_PULSE, 1'b0, 1'b1, 1'b1,
      '{1'b0, 1'b0, 23'd0, 2'b00, 1'b0}},
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_PULSE, 1'b1, 1'b0, 1'b1,
      '{1'b0, 1'b1, 23'd0, 2'b00, 1'b0}},
    '{STEP_REG, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, '0},
    '{STEP_REG, pfm_pkg::REG_LOW_FLOW_A, 32'h7F_FFFF, pfm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, '0},
    '{STEP_REG, pfm_pkg::REG_LOW_FLOW_B, 32'd0, pfm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, '0},
    '{STEP_REG, pfm_pkg::REG_ALARM_LIMIT, 32'd1, pfm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, '0},
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_PULSE, 1'b0, 1'b0, 1'b0, '0},
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_PULSE, 1'b0, 1'b1, 1'b0, '0},
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, '0},
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_PULSE, 1'b0, 1'b0, 1'b0, '0},
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_TICK, 1'b1, 1'b0, 1'b0, '0},
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_PULSE, 1'b1, 1'b1, 1'b0, '0},
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_TICK, 1'b0, 1'b1, 1'b0, '0},
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_PULSE, 1'b0, 1'b1, 1'b0, '0},
    '{STEP_BEAT, pfm_pkg::REG_WINDOW_LIMIT, 32'd0, pfm_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, '0}
  };

  pulse_flow_meter_low_flow_alarm_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic flow_rsp_t meter_step(input pfm_pkg::op_e op, input logic ch,
                                           input logic key);
    flow_rsp_t r;
    logic [pfm_pkg::FLOW_W-1:0] reading;
    r = '0;
    if (op == pfm_pkg::OP_TICK) begin
      for (int i = 0; i < 2; i++) begin
        if (mtr_ticks[i] != pfm_pkg::CNT_MAX) mtr_ticks[i] = mtr_ticks[i] + 1'b1;
      end
    end else begin
      r.chan = ch;
      if (mtr_pulses[ch] != pfm_pkg::CNT_MAX) mtr_pulses[ch] = mtr_pulses[ch] + 1'b1;
      if (mtr_ticks[ch] > cfg_window) begin
        mtr_ticks[ch]  = '0;
        reading        = mtr_pulses[ch] * pfm_pkg::FLOW_W'(FLOW_PER_PULSE);
        mtr_pulses[ch] = '0;
        r.valid        = 1'b1;
        r.value        = reading;
        if (reading <= cfg_low[ch]) begin
          if (mtr_low[ch] != pfm_pkg::LOW_W'(15)) mtr_low[ch] = mtr_low[ch] + 1'b1;
          if (mtr_low[ch] > cfg_alarm_lim && key) begin
            mtr_alarm[ch] = 1'b1;
            mtr_laser     = 1'b1;
          end
        end else begin
          mtr_low[ch] = '0;
        end
      end
    end
    r.alarm = mtr_alarm;
    r.laser = mtr_laser;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic send_beat(input pfm_pkg::op_e op, input logic ch, input logic key,
                           input bit typed, input flow_rsp_t given);
    flow_rsp_t calc;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, key, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    calc = meter_step(op, ch, key);
    flow_q.push_back(typed ? given : calc);
    beats_in++;
  endtask

  // drain: stop offering and wait for every pending result
  task automatic settle();
    s_tvalid <= 1'b0;
    while (flow_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // write, then read back
  task automatic reg_write(input pfm_pkg::reg_idx_e idx, input logic [31:0] val);
    logic [31:0] want;
    want = '0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      pfm_pkg::REG_WINDOW_LIMIT: begin
        cfg_window = val[pfm_pkg::CNT_W-1:0];
        want       = 32'(cfg_window);
      end
      pfm_pkg::REG_LOW_FLOW_A: begin
        cfg_low[0] = val[pfm_pkg::FLOW_W-1:0];
        want       = 32'(cfg_low[0]);
      end
      pfm_pkg::REG_LOW_FLOW_B: begin
        cfg_low[1] = val[pfm_pkg::FLOW_W-1:0];
        want       = 32'(cfg_low[1]);
      end
      pfm_pkg::REG_ALARM_LIMIT: begin
        cfg_alarm_lim = val[pfm_pkg::LOW_W-1:0];
        want          = 32'(cfg_alarm_lim);
      end
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always begin
    @(posedge clk_i);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      m_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      m_tready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : rsp_check
    flow_rsp_t want;
    if (rst_ni && m_axis_tvalid && m_tready) begin
      beats_out++;
      if (flow_q.size() == 0) begin
        report_mismatch("beat with nothing pending", m_axis_tdata, '0);
      end else begin
        want = flow_q.pop_front();
        if (m_axis_tuser !== want.valid)
          report_mismatch("flow_valid", 32'(m_axis_tuser), 32'(want.valid));
        if (m_axis_tdata[0] !== want.chan)
          report_mismatch("flow_channel", 32'(m_axis_tdata[0]), 32'(want.chan));
        if (m_axis_tdata[23:1] !== want.value)
          report_mismatch("flow_value", 32'(m_axis_tdata[23:1]), 32'(want.value));
        if (m_axis_tdata[25:24] !== want.alarm)
          report_mismatch("alarm_bits", 32'(m_axis_tdata[25:24]), 32'(want.alarm));
        if (m_axis_tdata[26] !== want.laser)
          report_mismatch("laser_off", 32'(m_axis_tdata[26]), 32'(want.laser));
        if (m_axis_tdata[31:27] !== '0)
          report_mismatch("tdata fill", 32'(m_axis_tdata[31:27]), '0);
        if (want.valid) readings++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               quiet_cycles, flow_q.size());
      $display("tb_pulse_flow_meter_low_flow_alarm_top: FAIL");
      $finish;
    end
  end

  initial begin
    pfm_pkg::op_e op;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    foreach (script[i]) begin
      if (script[i].kind == STEP_REG) begin
        settle();
        reg_write(script[i].idx, script[i].val);
      end else begin
        send_beat(script[i].op, script[i].ch, script[i].key, script[i].typed,
                  script[i].want);
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin
          // low-window count saturates on channel 1, never alarms
          reg_write(pfm_pkg::REG_WINDOW_LIMIT, 32'd0);
          reg_write(pfm_pkg::REG_LOW_FLOW_A, 32'd0);
          reg_write(pfm_pkg::REG_LOW_FLOW_B, 32'h7F_FFFF);
          reg_write(pfm_pkg::REG_ALARM_LIMIT, 32'd15);
        end
        1: begin
          reg_write(pfm_pkg::REG_WINDOW_LIMIT, 32'd2);
          reg_write(pfm_pkg::REG_LOW_FLOW_A, 32'd285);
          reg_write(pfm_pkg::REG_LOW_FLOW_B, 32'd190);
          reg_write(pfm_pkg::REG_ALARM_LIMIT, 32'd1);
        end
        2: begin
          reg_write(pfm_pkg::REG_WINDOW_LIMIT, 32'($urandom_range(0, 6)));
          reg_write(pfm_pkg::REG_LOW_FLOW_A, 32'($urandom_range(0, 1000)));
          reg_write(pfm_pkg::REG_LOW_FLOW_B, $urandom & 32'h7F_FFFF);
          reg_write(pfm_pkg::REG_ALARM_LIMIT, 32'($urandom_range(0, 14)));
        end
        3: begin
          reg_write(pfm_pkg::REG_WINDOW_LIMIT, 32'($urandom_range(0, 6)));
          reg_write(pfm_pkg::REG_LOW_FLOW_A, $urandom & 32'h7F_FFFF);
          reg_write(pfm_pkg::REG_LOW_FLOW_B, 32'($urandom_range(0, 600)));
          reg_write(pfm_pkg::REG_ALARM_LIMIT, 32'd0);
        end
        default: begin
          reg_write(pfm_pkg::REG_WINDOW_LIMIT, 32'd1);
          reg_write(pfm_pkg::REG_LOW_FLOW_A, 32'd380);
          reg_write(pfm_pkg::REG_LOW_FLOW_B, 32'd380);
          reg_write(pfm_pkg::REG_ALARM_LIMIT, 32'd14);
        end
      endcase
      idle_on = (ph != 4);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 1 && n == 30) hold_off_req = 1'b1;
        if ($urandom_range(0, 9) < 4) op = pfm_pkg::OP_TICK;
        else op = pfm_pkg::OP_PULSE;
        send_beat(op, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0), 1'b0, '0);
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("run: %0d beats in, %0d out, %0d window readings, %0d register writes",
             beats_in, beats_out, readings, reg_writes);
    $display("window closing, low-window saturation, alarm latching, long stall; alarms %b",
             mtr_alarm);
    if (mismatches == 0) begin
      $display("tb_pulse_flow_meter_low_flow_alarm_top: PASS");
    end else begin
      $display("tb_pulse_flow_meter_low_flow_alarm_top: FAIL");
    end
    $finish;
  end

endmodule
